FILE: sv/gsm_pkg.sv
// ============================================================================
// gsm_pkg: shared types and constants for the generational slot map
// Operation and status codes, field widths of the stream transactions and
// parameter defaults.
// ============================================================================
`default_nettype none

package gsm_pkg;

    // Parameter defaults
    localparam int DEF_SLOTS      = 256;
    localparam int DEF_VALUE_BITS = 32;
    localparam int DEF_GEN_BITS   = 32;

    // Field widths of the input transaction
    localparam int OP_W       = 2;
    localparam int KEY_SLOT_W = 8;
    localparam int KEY_GEN_W  = 32;
    localparam int VALUE_W    = 32;
    localparam int IN_TDATA_W = 80;

    // Field widths of the result transaction
    localparam int STATUS_W    = 2;
    localparam int OUT_SLOT_W  = 8;
    localparam int OUT_GEN_W   = 32;
    localparam int OUT_VALUE_W = 32;
    localparam int LIVE_W      = 9;
    localparam int OUT_TDATA_W = 88;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 2'd0,
        OP_GET    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EXHAUSTED = 2'd2,
        ST_STALE     = 2'd3
    } status_t;

endpackage

`default_nettype wire

FILE: sv/gsm_ram.sv
// ============================================================================
// gsm_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ============================================================================
`default_nettype none

module gsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

FILE: sv/generational_slot_map.sv
// ============================================================================
// generational_slot_map: handle allocator with generation checks
// Add pops a free slot and issues a (slot, generation) key, get checks a key
// and returns the stored value, remove frees a slot and keeps the values
// dense, clear rebuilds the free chain.
// ============================================================================
//
//   Channel     Direction  Width  Contents
//   s_axis_*    in         80     op, key_slot, key_gen, value
//   m_axis_*    out        88     status, out_slot, out_gen, out_value, live_total
//
// Steps after acceptance: S_CHECK answers full, exhausted and out-of-range
// keys; add goes on to S_ADD; get and remove go to S_KEY, which answers
// stale keys, then get to S_GET and remove to S_MOVE when the last dense
// entry moves into the hole; clear sweeps in S_CLEAR. Each step waits on
// the registered read of a slot or dense RAM, and the RAMs' single write
// ports carry one update each per cycle. After reset a sweep over all SLOTS
// slots builds the free chain before the first transaction is taken. While
// a result waits to be taken, the sequencer holds its step; a sweep holds its last slot.
`default_nettype none

module generational_slot_map #(
    parameter int SLOTS      = gsm_pkg::DEF_SLOTS,
    parameter int VALUE_BITS = gsm_pkg::DEF_VALUE_BITS,
    parameter int GEN_BITS   = gsm_pkg::DEF_GEN_BITS
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // op [1:0], key_slot [9:2], key_gen [41:10], value [73:42], zero [79:74]
    input  wire logic [gsm_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // status [1:0], out_slot [9:2], out_gen [41:10], out_value [73:42],
    // live_total [82:74], zero [87:83]
    output logic [gsm_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

    import gsm_pkg::*;

    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int LINK_W  = $clog2(SLOTS + 1);
    localparam int DENSE_W = VALUE_BITS + SLOT_W;
    localparam logic [GEN_BITS-1:0] GEN_INVALID = '1;

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_CHECK = 7'b0000100,
        S_ADD   = 7'b0001000,
        S_KEY   = 7'b0010000,
        S_GET   = 7'b0100000,
        S_MOVE  = 7'b1000000
    } state_t;

    // Control registers
    state_t              state_reg, state_next;
    logic [LINK_W-1:0]   free_head_reg, free_head_next;
    logic [GEN_BITS-1:0] next_gen_reg, next_gen_next;
    logic [LINK_W-1:0]   live_reg, live_next;
    logic [SLOT_W-1:0]   clr_idx_reg, clr_idx_next;
    logic                clr_reply_reg, clr_reply_next;
    logic                out_valid_reg, out_valid_next;

    // Payload registers
    op_t                 op_reg;
    logic [KEY_SLOT_W-1:0] key_slot_reg;
    logic [KEY_GEN_W-1:0]  key_gen_reg;
    logic [VALUE_W-1:0]    value_reg;
    logic [LINK_W-1:0]   hole_reg, hole_next;
    status_t             out_status_reg;
    logic [OUT_SLOT_W-1:0]  out_slot_reg;
    logic [OUT_GEN_W-1:0]   out_gen_reg;
    logic [OUT_VALUE_W-1:0] out_value_reg;
    logic [LIVE_W-1:0]      out_live_reg;

    // Result being formed
    logic                   out_load;
    status_t                res_status;
    logic [OUT_SLOT_W-1:0]  res_slot;
    logic [OUT_GEN_W-1:0]   res_gen;
    logic [OUT_VALUE_W-1:0] res_value;

    // RAM ports
    logic                link_we, gen_we, dense_we;
    logic [SLOT_W-1:0]   link_wa, gen_wa, dense_wa;
    logic [LINK_W-1:0]   link_wd;
    logic [GEN_BITS-1:0] gen_wd;
    logic [DENSE_W-1:0]  dense_wd;
    logic [SLOT_W-1:0]   link_ra, gen_ra, dense_ra;
    logic [LINK_W-1:0]   link_rd;
    logic [GEN_BITS-1:0] gen_rd;
    logic [DENSE_W-1:0]  dense_rd;

    // Derived values
    logic                in_accept;
    logic                res_ok;
    logic [SLOT_W-1:0]   ks_idx;
    logic [SLOT_W-1:0]   fh_idx;
    logic [SLOT_W-1:0]   live_idx;
    logic [LINK_W-1:0]   live_m1;
    logic                table_full;
    logic                key_pre_bad;

    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign res_ok        = !out_valid_reg || m_axis_tready;
    assign ks_idx        = SLOT_W'(key_slot_reg);
    assign fh_idx        = free_head_reg[SLOT_W-1:0];
    assign live_idx      = live_reg[SLOT_W-1:0];
    assign live_m1       = live_reg - 1'b1;
    assign table_full    = (32'(free_head_reg) >= 32'(SLOTS)) ||
                           (32'(live_reg) >= 32'(SLOTS));
    assign key_pre_bad   = (32'(key_slot_reg) >= 32'(SLOTS)) ||
                           (key_gen_reg >= 32'(GEN_INVALID));

    // Read addresses come from held registers so a stalled step re-reads
    assign link_ra  = (op_reg == OP_ADD) ? fh_idx : ks_idx;
    assign gen_ra   = ks_idx;
    assign dense_ra = (op_reg == OP_GET) ? link_rd[SLOT_W-1:0] : live_m1[SLOT_W-1:0];

    // Slot links: next free slot, or dense index of a live slot
    gsm_ram #(.WIDTH(LINK_W), .DEPTH(SLOTS)) u_link_ram (
        .clk     (clk),
        .wr_en   (link_we),
        .wr_addr (link_wa),
        .wr_data (link_wd),
        .rd_addr (link_ra),
        .rd_data (link_rd)
    );

    // Slot generations
    gsm_ram #(.WIDTH(GEN_BITS), .DEPTH(SLOTS)) u_gen_ram (
        .clk     (clk),
        .wr_en   (gen_we),
        .wr_addr (gen_wa),
        .wr_data (gen_wd),
        .rd_addr (gen_ra),
        .rd_data (gen_rd)
    );

    // Dense values with their owning slot
    gsm_ram #(.WIDTH(DENSE_W), .DEPTH(SLOTS)) u_dense_ram (
        .clk     (clk),
        .wr_en   (dense_we),
        .wr_addr (dense_wa),
        .wr_data (dense_wd),
        .rd_addr (dense_ra),
        .rd_data (dense_rd)
    );

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        free_head_next = free_head_reg;
        next_gen_next  = next_gen_reg;
        live_next      = live_reg;
        clr_idx_next   = clr_idx_reg;
        clr_reply_next = clr_reply_reg;
        hole_next      = hole_reg;

        link_we  = 1'b0;
        link_wa  = ks_idx;
        link_wd  = free_head_reg;
        gen_we   = 1'b0;
        gen_wa   = ks_idx;
        gen_wd   = GEN_INVALID;
        dense_we = 1'b0;
        dense_wa = live_idx;
        dense_wd = {VALUE_BITS'(value_reg), fh_idx};

        out_load   = 1'b0;
        res_status = ST_OK;
        res_slot   = '0;
        res_gen    = '0;
        res_value  = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                // Rebuild one link of the free chain per cycle
                link_we = 1'b1;
                link_wa = clr_idx_reg;
                link_wd = LINK_W'(clr_idx_reg) + 1'b1;
                gen_we  = 1'b1;
                gen_wa  = clr_idx_reg;
                gen_wd  = GEN_INVALID;
                if (clr_idx_reg != SLOT_W'(SLOTS - 1))
                begin
                    clr_idx_next = clr_idx_reg + 1'b1;
                end
                else if (!clr_reply_reg || res_ok)
                begin
                    clr_idx_next   = '0;
                    clr_reply_next = 1'b0;
                    out_load       = clr_reply_reg;
                    state_next     = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = S_CHECK;
                end
            end

            S_CHECK:
            begin
                if (res_ok)
                begin
                    unique case (op_reg) inside
                        OP_ADD:
                        begin
                            if (table_full)
                            begin
                                res_status = ST_FULL;
                                out_load   = 1'b1;
                                state_next = S_IDLE;
                            end
                            else if (next_gen_reg == GEN_INVALID)
                            begin
                                res_status = ST_EXHAUSTED;
                                out_load   = 1'b1;
                                state_next = S_IDLE;
                            end
                            else
                            begin
                                state_next = S_ADD;
                            end
                        end
                        OP_GET, OP_REMOVE:
                        begin
                            if (key_pre_bad)
                            begin
                                res_status = ST_STALE;
                                out_load   = 1'b1;
                                state_next = S_IDLE;
                            end
                            else
                            begin
                                state_next = S_KEY;
                            end
                        end
                        default:
                        begin
                            // Empty the map, then sweep the free chain
                            free_head_next = '0;
                            next_gen_next  = '0;
                            live_next      = '0;
                            clr_idx_next   = '0;
                            clr_reply_next = 1'b1;
                            state_next     = S_CLEAR;
                        end
                    endcase
                end
            end

            S_ADD:
            begin
                // Pop the head slot, stamp it and append the value
                if (res_ok)
                begin
                    free_head_next = link_rd;
                    link_we        = 1'b1;
                    link_wa        = fh_idx;
                    link_wd        = live_reg;
                    gen_we         = 1'b1;
                    gen_wa         = fh_idx;
                    gen_wd         = next_gen_reg;
                    dense_we       = 1'b1;
                    dense_wa       = live_idx;
                    dense_wd       = {VALUE_BITS'(value_reg), fh_idx};
                    next_gen_next  = next_gen_reg + 1'b1;
                    live_next      = live_reg + 1'b1;
                    res_slot       = OUT_SLOT_W'(free_head_reg);
                    res_gen        = OUT_GEN_W'(next_gen_reg);
                    out_load       = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            S_KEY:
            begin
                if (res_ok)
                begin
                    if ((gen_rd != GEN_BITS'(key_gen_reg)) || (link_rd >= live_reg))
                    begin
                        res_status = ST_STALE;
                        out_load   = 1'b1;
                        state_next = S_IDLE;
                    end
                    else if (op_reg == OP_GET)
                    begin
                        state_next = S_GET;
                    end
                    else
                    begin
                        // Push the slot back on the free list
                        link_we        = 1'b1;
                        link_wa        = ks_idx;
                        link_wd        = free_head_reg;
                        gen_we         = 1'b1;
                        gen_wa         = ks_idx;
                        gen_wd         = GEN_INVALID;
                        free_head_next = LINK_W'(key_slot_reg);
                        hole_next      = link_rd;
                        if (link_rd < live_m1)
                        begin
                            state_next = S_MOVE;
                        end
                        else
                        begin
                            live_next  = live_m1;
                            out_load   = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                end
            end

            S_GET:
            begin
                if (res_ok)
                begin
                    res_value  = OUT_VALUE_W'(dense_rd[DENSE_W-1:SLOT_W]);
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_MOVE:
            begin
                // Move the last dense entry into the hole and fix its owner
                if (res_ok)
                begin
                    dense_we   = 1'b1;
                    dense_wa   = hole_reg[SLOT_W-1:0];
                    dense_wd   = dense_rd;
                    link_we    = 1'b1;
                    link_wa    = dense_rd[SLOT_W-1:0];
                    link_wd    = hole_reg;
                    live_next  = live_m1;
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // Hold the result until the consumer takes it
    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            free_head_reg <= '0;
            next_gen_reg  <= '0;
            live_reg      <= '0;
            clr_idx_reg   <= '0;
            clr_reply_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            free_head_reg <= free_head_next;
            next_gen_reg  <= next_gen_next;
            live_reg      <= live_next;
            clr_idx_reg   <= clr_idx_next;
            clr_reply_reg <= clr_reply_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload: capture the transaction, the hole and the result
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg       <= op_t'(s_axis_tdata[1:0]);
            key_slot_reg <= s_axis_tdata[9:2];
            key_gen_reg  <= s_axis_tdata[41:10];
            value_reg    <= s_axis_tdata[73:42];
        end
        hole_reg <= hole_next;
        if (out_load)
        begin
            out_status_reg <= res_status;
            out_slot_reg   <= res_slot;
            out_gen_reg    <= res_gen;
            out_value_reg  <= res_value;
            out_live_reg   <= LIVE_W'(live_next);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_live_reg, out_value_reg, out_gen_reg,
                            out_slot_reg, out_status_reg};

    // Checks
    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(live_reg) <= 32'(SLOTS))
        else $error("live count above slot count");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> !s_axis_tready)
        else $error("second transaction taken while busy");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || m_axis_tready))
        else $error("result register overwritten before it was taken");

    a_gen_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ADD && res_ok) |=> next_gen_reg == $past(next_gen_reg) + 1'b1)
        else $error("generation did not advance by one on add");

endmodule

`default_nettype wire
